@@ src/tgf_pkg.sv @@
package tgf_pkg;

    typedef enum logic [1:0] {
        CMD_ASSIGN  = 2'd0,
        CMD_ENQUEUE = 2'd1,
        CMD_DEQUEUE = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_FULL       = 2'd2,
        ST_UNASSIGNED = 2'd3
    } status_t;

    localparam int unsigned ElemW   = 10;
    localparam int unsigned TeamW   = 4;
    localparam int unsigned CmdW    = 2;
    localparam int unsigned InW     = 16;
    localparam int unsigned OutW    = 16;

endpackage

@@ src/team_grouped_fifo_core.sv @@
// channel | ports               | tdata fields (low bit up)
// s_      | s_tvalid/s_tready   | command[1:0] element[11:2] team[15:12]
// m_      | m_tvalid/m_tready   | out_element[9:0] has_element[10] status[12:11], pad
// each word passes through these steps: accept with membership, free stack and team
// order reads, team head and tail read, slot read and enqueue write back, dequeue
// write back with the result loaded, then the result held on the output until taken
// the result is offered once its word has passed the read, exec and link states
// after reset and after a clear every membership table entry is cleared by a sweep,
// while s_tready stays low
// a stalled output holds the block; a new word is taken once the result has left
module team_grouped_fifo_core #(
    parameter int ID_BITS   = 10,
    parameter int MAX_TEAMS = 16,
    parameter int CAPACITY  = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [tgf_pkg::InW-1:0]  s_tdata,   // command, element, team
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [tgf_pkg::OutW-1:0] m_tdata    // out_element, has_element, status
);
    import tgf_pkg::*;

    localparam int IdN   = 1 << ID_BITS;
    localparam int TmW   = (MAX_TEAMS > 1) ? $clog2(MAX_TEAMS) : 1;
    localparam int SlW   = $clog2(CAPACITY);
    localparam int CntW  = $clog2(CAPACITY + 1);
    localparam int OcW   = $clog2(MAX_TEAMS + 1);
    localparam int MtW   = TmW + 1;

    typedef enum logic [2:0] {S_SWEEP, S_IDLE, S_READ, S_EXEC, S_LINK, S_OUT} state_t;

    // memories
    logic [MtW-1:0]  member_mem [IdN];
    logic [ElemW-1:0] elem_mem  [CAPACITY];
    logic [SlW-1:0]  next_mem   [CAPACITY];
    logic [SlW-1:0]  free_mem   [CAPACITY];
    logic [SlW-1:0]  head_mem   [MAX_TEAMS];
    logic [SlW-1:0]  tail_mem   [MAX_TEAMS];
    logic [TmW-1:0]  order_mem  [MAX_TEAMS];

    state_t             state_reg;
    logic [ID_BITS:0]   sweep_reg;
    logic [CntW-1:0]    count_reg;
    logic [SlW:0]       freeinit_reg;  // free stack entries at or above this were written
    logic [MAX_TEAMS-1:0] waiting_reg;
    logic [TmW-1:0]     ohead_reg;
    logic [OcW-1:0]     ocount_reg;
    cmd_t               cmd_reg;
    logic [ID_BITS-1:0] elem_reg;
    logic [TeamW-1:0]   team_reg;
    logic [MtW-1:0]     mt_rd;
    logic [SlW-1:0]     free_rd, head_rd, tail_rd, next_rd, slot_reg;
    logic [ElemW-1:0]   elem_rd;
    logic [TmW-1:0]     oteam_rd, tm_reg;
    logic [ElemW-1:0]   oel_reg;
    logic               has_reg;
    status_t            st_reg;

    logic [ID_BITS-1:0] s_elem;
    logic [SlW-1:0] fidx;
    logic [TmW:0]   ord_sum;
    logic [TmW-1:0] ord_wr;
    assign s_elem   = ID_BITS'(s_tdata[11:2]);
    assign fidx     = SlW'(CAPACITY - 1 - int'(count_reg));
    assign ord_sum  = {1'b0, ohead_reg} + (TmW+1)'(ocount_reg);
    assign ord_wr   = (ord_sum >= (TmW+1)'(MAX_TEAMS)) ?
                      TmW'(ord_sum - (TmW+1)'(MAX_TEAMS)) : TmW'(ord_sum);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tdata  = {3'b000, st_reg, has_reg, oel_reg};

    logic [SlW-1:0] free_val;
    assign free_val = ({1'b0, fidx} >= freeinit_reg) ? free_rd : fidx;
    logic [TmW-1:0] eteam;
    assign eteam = TmW'(mt_rd - 1'b1);

    // memory access
    always_ff @(posedge aclk) begin
        if (state_reg == S_SWEEP) begin
            member_mem[sweep_reg[ID_BITS-1:0]] <= '0;
        end else if (state_reg == S_IDLE && s_tvalid) begin
            mt_rd <= member_mem[s_elem];
            free_rd <= free_mem[fidx];
            oteam_rd <= order_mem[ohead_reg];
        end else if (state_reg == S_READ) begin
            if (cmd_reg == CMD_ASSIGN && int'(team_reg) < MAX_TEAMS)
                member_mem[elem_reg] <= MtW'(int'(team_reg) + 1);
            head_rd <= head_mem[cmd_reg == CMD_DEQUEUE ? oteam_rd : eteam];
            tail_rd <= tail_mem[cmd_reg == CMD_DEQUEUE ? oteam_rd : eteam];
        end else if (state_reg == S_EXEC) begin
            elem_rd <= elem_mem[head_rd];
            next_rd <= next_mem[head_rd];
            if (cmd_reg == CMD_ENQUEUE && mt_rd != '0 && int'(count_reg) < CAPACITY) begin
                elem_mem[free_val] <= ElemW'(elem_reg);
                if (waiting_reg[eteam]) begin
                    next_mem[tail_rd] <= free_val;
                end else begin
                    head_mem[eteam] <= free_val;
                    order_mem[ord_wr] <= eteam;
                end
                tail_mem[eteam] <= free_val;
            end
        end else if (state_reg == S_LINK) begin
            if (cmd_reg == CMD_DEQUEUE && has_reg) begin
                free_mem[fidx] <= head_rd;
                if (head_rd != tail_rd)
                    head_mem[tm_reg] <= next_rd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_SWEEP;
            sweep_reg    <= '0;
            count_reg    <= '0;
            freeinit_reg <= (SlW+1)'(CAPACITY);
            waiting_reg  <= '0;
            ohead_reg    <= '0;
            ocount_reg   <= '0;
            m_tvalid     <= 1'b0;
        end else begin
            case (state_reg)
                S_SWEEP: begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (int'(sweep_reg) == IdN - 1) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg   <= cmd_t'(s_tdata[1:0]);
                        elem_reg  <= s_elem;
                        team_reg  <= s_tdata[12 +: TeamW];
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    oel_reg <= '0;
                    has_reg <= 1'b0;
                    st_reg  <= ST_OK;
                    tm_reg  <= oteam_rd;
                    if (cmd_reg == CMD_DEQUEUE) begin
                        if (count_reg == '0 || ocount_reg == '0) st_reg <= ST_EMPTY;
                        else has_reg <= 1'b1;
                    end
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    if (cmd_reg == CMD_ENQUEUE) begin
                        if (mt_rd == '0) st_reg <= ST_UNASSIGNED;
                        else if (int'(count_reg) >= CAPACITY) st_reg <= ST_FULL;
                        else begin
                            count_reg <= count_reg + 1'b1;
                            if (!waiting_reg[eteam]) begin
                                waiting_reg[eteam] <= 1'b1;
                                if (int'(ocount_reg) < MAX_TEAMS)
                                    ocount_reg <= ocount_reg + 1'b1;
                            end
                        end
                    end
                    if (cmd_reg == CMD_DEQUEUE && has_reg)
                        count_reg <= count_reg - 1'b1;
                    state_reg <= S_LINK;
                end
                S_LINK: begin
                    if (cmd_reg == CMD_DEQUEUE && has_reg) begin
                        oel_reg <= elem_rd;
                        if ({1'b0, fidx} < freeinit_reg)
                            freeinit_reg <= {1'b0, fidx};
                        if (head_rd == tail_rd) begin
                            waiting_reg[tm_reg] <= 1'b0;
                            ohead_reg  <= (int'(ohead_reg) == MAX_TEAMS - 1) ?
                                          '0 : ohead_reg + 1'b1;
                            ocount_reg <= ocount_reg - 1'b1;
                        end
                    end
                    m_tvalid  <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) begin
                        m_tvalid <= 1'b0;
                        if (cmd_reg == CMD_CLEAR) begin
                            state_reg    <= S_SWEEP;
                            sweep_reg    <= '0;
                            count_reg    <= '0;
                            freeinit_reg <= (SlW+1)'(CAPACITY);
                            waiting_reg  <= '0;
                            ohead_reg    <= '0;
                            ocount_reg   <= '0;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_SWEEP;
            endcase
        end
    end

endmodule

@@ src/tgf_checker.sv @@
module tgf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import tgf_pkg::*;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_has_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10] |-> m_tdata[12:11] == ST_OK) else $error("bad status");
    a_zero_el: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[10] |-> m_tdata[9:0] == '0) else $error("stray element");
endmodule

bind team_grouped_fifo_core tgf_checker u_tgf_checker (.*);
